### hdl/sci_pkg.sv
package sci_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 32;
   localparam int PTR_W       = $clog2(STACK_DEPTH);

   typedef logic [PTR_W-1:0] ptr_type;

   // Memory-mapped I/O addresses
   localparam logic [15:0] IO_KEY   = 16'hF000;
   localparam logic [15:0] IO_ONE   = 16'hF001;
   localparam logic [15:0] IO_RSTK  = 16'hF002;

   // Instruction kinds, bits 14..13 when bit 15 is clear
   typedef enum logic [1:0] {
      KIND_JMP  = 2'd0,
      KIND_JZ   = 2'd1,
      KIND_CALL = 2'd2,
      KIND_ALU  = 2'd3
   } insn_kind_type;

   // Stack pointer adjustments
   typedef enum logic [1:0] {
      DELTA_NONE  = 2'd0,
      DELTA_UP    = 2'd1,
      DELTA_DOWN2 = 2'd2,
      DELTA_DOWN1 = 2'd3
   } delta_type;

   // ALU operations, bits 11..8
   typedef enum logic [3:0] {
      OP_T     = 4'h0,
      OP_N     = 4'h1,
      OP_ADD   = 4'h2,
      OP_AND   = 4'h3,
      OP_OR    = 4'h4,
      OP_XOR   = 4'h5,
      OP_INV   = 4'h6,
      OP_EQ    = 4'h7,
      OP_LT    = 4'h8,
      OP_RSH   = 4'h9,
      OP_DEC   = 4'hA,
      OP_R     = 4'hB,
      OP_LOAD  = 4'hC,
      OP_LSH   = 4'hD,
      OP_DEPTH = 4'hE,
      OP_ULT   = 4'hF
   } alu_op_type;

   typedef struct packed {
      logic [15:0] instruction;
      logic [15:0] load_data;
   } req_type;

   typedef struct packed {
      logic [14:0] fetch_addr;
      logic [15:0] top_value;
      logic        mem_write;
      logic [14:0] write_addr;
      logic [15:0] write_data;
      logic        char_valid;
      logic [7:0]  char_data;
      logic        key_taken;
   } rsp_type;

   // One write into a stack
   typedef struct packed {
      logic        en;
      ptr_type     addr;
      logic [15:0] data;
   } stk_wr_type;

   // Operands presented to the ALU
   typedef struct packed {
      alu_op_type  op;
      logic [15:0] t;
      logic [15:0] s;
      logic [15:0] rtop;
      logic [15:0] load;
      ptr_type     dp;
      ptr_type     rp;
   } alu_in_type;

   // Move a stack pointer by a delta code, wrapping modulo the depth
   function automatic ptr_type wrap_ptr(ptr_type p, delta_type code);
      ptr_type r;
      r = p;
      case (code)
         DELTA_UP:    r = (int'(p) == STACK_DEPTH - 1) ? '0 : ptr_type'(int'(p) + 1);
         DELTA_DOWN1: r = (p == '0) ? ptr_type'(STACK_DEPTH - 1) : ptr_type'(int'(p) - 1);
         DELTA_DOWN2: r = (int'(p) >= 2) ? ptr_type'(int'(p) - 2)
                                         : ptr_type'(int'(p) + STACK_DEPTH - 2);
         default:     r = p;
      endcase
      return r;
   endfunction

endpackage

### hdl/sci_stack.sv
module sci_stack
   import sci_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ptr_type     rd_ptr,
   input  stk_wr_type  wr,
   output logic [15:0] rd_data
);

   logic [15:0]            mem_ff [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] valid_ff;
   logic [STACK_DEPTH-1:0] valid_in;

   // Entries never written read as zero
   assign rd_data = valid_ff[rd_ptr] ? mem_ff[rd_ptr] : '0;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

endmodule

### hdl/sci_alu.sv
module sci_alu
   import sci_pkg::*;
(
   input  alu_in_type  alu_in,
   output logic [15:0] result,
   output logic        key_taken
);

   logic [15:0] t;
   logic [15:0] s;
   logic        big_shift;

   assign t         = alu_in.t;
   assign s         = alu_in.s;
   assign big_shift = |t[15:4];

   always_comb begin
      result    = '0;
      key_taken = 1'b0;
      unique case (alu_in.op)
         OP_T:     result = t;
         OP_N:     result = s;
         OP_ADD:   result = t + s;
         OP_AND:   result = t & s;
         OP_OR:    result = t | s;
         OP_XOR:   result = t ^ s;
         OP_INV:   result = ~t;
         OP_EQ:    result = (t == s) ? 16'hFFFF : 16'h0000;
         OP_LT:    result = ($signed(s) < $signed(t)) ? 16'hFFFF : 16'h0000;
         OP_RSH:   result = big_shift ? 16'h0000 : (s >> t[3:0]);
         OP_DEC:   result = t - 16'd1;
         OP_R:     result = alu_in.rtop;
         OP_LOAD: begin
            if (t == IO_ONE) begin
               result = 16'd1;
            end else begin
               result    = alu_in.load;
               key_taken = (t == IO_KEY);
            end
         end
         OP_LSH:   result = big_shift ? 16'h0000 : (s << t[3:0]);
         OP_DEPTH: result = {8'(alu_in.rp), 8'(alu_in.dp)};
         OP_ULT:   result = (s < t) ? 16'hFFFF : 16'h0000;
         default:  result = '0;
      endcase
   end

endmodule

### hdl/stack_cpu_instruction_step.sv
// Two-stack Forth processor core that executes one 16-bit instruction per
// request. Each request carries the instruction fetched at the last reported
// fetch address and the memory word at (top >> 1), or the key code when the
// top is 0xF000; the response gives the next fetch address, the new top of
// stack and the store, character and key strobes. A request is captured in
// an input register and executed once the response register is free or being
// drained, when the stacks, pointers, top and program counter update and the
// response register loads; a new request is taken every cycle as long
// as the response side keeps up. The response register keeps a finished
// response while the next request is being captured. Both stacks are
// STACK_DEPTH deep and wrap silently; they read as zero after reset.
module stack_cpu_instruction_step
   import sci_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;

   // Response register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   // Architectural state
   logic [15:0] top_ff;
   logic [15:0] top_in;
   logic [14:0] pc_ff;
   logic [14:0] pc_in;
   ptr_type     dp_ff;
   ptr_type     dp_in;
   ptr_type     rp_ff;
   ptr_type     rp_in;

   logic        accept;
   logic        advance;

   logic [15:0] insn;
   logic [15:0] nos;
   logic [15:0] rtop;
   logic [14:0] pc_inc;
   logic [14:0] target;
   ptr_type     rp_moved;
   stk_wr_type  dwr;
   stk_wr_type  rwr;
   alu_in_type  alu_in;
   logic [15:0] alu_result;
   logic        alu_key;

   // Handshake: execute when the response register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Stacks, read at the current pointers
   sci_stack u_dstack (
      .clock   (clock),
      .reset   (reset),
      .rd_ptr  (dp_ff),
      .wr      (dwr),
      .rd_data (nos)
   );

   sci_stack u_rstack (
      .clock   (clock),
      .reset   (reset),
      .rd_ptr  (rp_ff),
      .wr      (rwr),
      .rd_data (rtop)
   );

   assign insn   = in_data_ff.instruction;
   assign pc_inc = pc_ff + 15'd1;
   assign target = {2'b00, insn[12:0]};

   assign alu_in.op   = alu_op_type'(insn[11:8]);
   assign alu_in.t    = top_ff;
   assign alu_in.s    = nos;
   assign alu_in.rtop = rtop;
   assign alu_in.load = in_data_ff.load_data;
   assign alu_in.dp   = dp_ff;
   assign alu_in.rp   = rp_ff;

   sci_alu u_alu (
      .alu_in    (alu_in),
      .result    (alu_result),
      .key_taken (alu_key)
   );

   assign rp_moved = wrap_ptr(rp_ff, delta_type'(insn[3:2]));

   // Instruction execution: hold all state unless a request advances
   always_comb begin
      top_in      = top_ff;
      pc_in       = pc_ff;
      dp_in       = dp_ff;
      rp_in       = rp_ff;
      dwr         = '0;
      rwr         = '0;
      rsp_data_in = '0;

      if (advance) begin
         pc_in = pc_inc;
         if (insn[15]) begin
            // Literal: push old top, load the immediate
            dp_in     = wrap_ptr(dp_ff, DELTA_UP);
            dwr.en    = 1'b1;
            dwr.addr  = dp_in;
            dwr.data  = top_ff;
            top_in    = {1'b0, insn[14:0]};
         end else begin
            unique case (insn_kind_type'(insn[14:13]))
               KIND_JMP: begin
                  pc_in = target;
               end
               KIND_JZ: begin
                  // Pop the top; branch when it was zero
                  top_in = nos;
                  dp_in  = wrap_ptr(dp_ff, DELTA_DOWN1);
                  if (top_ff == '0) begin
                     pc_in = target;
                  end
               end
               KIND_CALL: begin
                  // Push the byte return address
                  rp_in    = wrap_ptr(rp_ff, DELTA_UP);
                  rwr.en   = 1'b1;
                  rwr.addr = rp_in;
                  rwr.data = {pc_inc, 1'b0};
                  pc_in    = target;
               end
               KIND_ALU: begin
                  if (insn[12]) begin
                     pc_in = rtop[15:1];
                  end
                  top_in   = alu_result;
                  dp_in    = wrap_ptr(dp_ff, delta_type'(insn[1:0]));
                  rp_in    = rp_moved;
                  dwr.en   = insn[7];
                  dwr.addr = dp_in;
                  dwr.data = top_ff;
                  rwr.en   = insn[6];
                  rwr.addr = rp_moved;
                  rwr.data = top_ff;
                  rsp_data_in.key_taken = alu_key;
                  if (insn[5]) begin
                     if (top_ff == IO_RSTK) begin
                        // Reset the return stack pointer after the copy above
                        rp_in = '0;
                     end else if (top_ff == IO_KEY) begin
                        rsp_data_in.char_valid = 1'b1;
                        rsp_data_in.char_data  = nos[7:0];
                     end else begin
                        rsp_data_in.mem_write  = 1'b1;
                        rsp_data_in.write_addr = top_ff[15:1];
                        rsp_data_in.write_data = nos;
                     end
                  end
               end
               default: begin
                  pc_in = pc_inc;
               end
            endcase
         end
         rsp_data_in.fetch_addr = pc_in;
         rsp_data_in.top_value  = top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
         pc_ff  <= '0;
         dp_ff  <= '0;
         rp_ff  <= '0;
      end else begin
         top_ff <= top_in;
         pc_ff  <= pc_in;
         dp_ff  <= dp_in;
         rp_ff  <= rp_in;
      end
   end

   // A store goes either to memory or to the character port, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.mem_write |-> !rsp_data_ff.char_valid)
      else $error("memory store and character output in one response");

   // Stall the request side only while a captured request is waiting
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input register");

   // An executed request always leaves a response behind
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("executed request produced no response");

   // The response register reports the state it just committed
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_data_ff.fetch_addr == pc_ff) && (rsp_data_ff.top_value == top_ff))
      else $error("response does not match committed state");

endmodule
